/* design/fdw_pkg.sv */
package fdw_pkg;

    // Field widths fixed by the on-disk format and the result layout.
    localparam int CLUSTER_W          = 16;
    localparam int SECTOR_W           = 7;
    localparam int SLOT_W             = 5;
    localparam int SHIFT_W            = 3;
    localparam int ADDR_W             = 24;
    localparam int BYTE_W             = 8;
    localparam int WORD_IDX_W         = 8;
    localparam int ENTRY_IDX_W        = 4;
    localparam int CMD_W              = 2;
    localparam int CFG_INDEX_W        = 2;
    localparam int CFG_DATA_W         = 16;
    localparam int ENTRIES_PER_SECTOR = 16;
    localparam int FIFO_DEPTH_DEF     = 4;

    // Markers in the FAT and in directory entries.
    localparam logic [CLUSTER_W-1:0] CHAIN_END = 16'hFFF8;
    localparam logic [BYTE_W-1:0]    NAME_FREE = 8'hE5;
    localparam logic [BYTE_W-1:0]    NAME_END  = 8'h00;

    // Command codes on the input channel.
    localparam logic [CMD_W-1:0] CMD_OPEN  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENTRY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FAT   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_CLUSTER_SHIFT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAT_START     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_CLUSTER  = 2'd2;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_FAT   = 2'd1,
        KIND_ENTRY = 2'd2,
        KIND_END   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [ADDR_W-1:0]      sector_address;
        logic [WORD_IDX_W-1:0]  fat_word_index;
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic                   last;
    } t_result;

    typedef struct packed {
        logic [CLUSTER_W-1:0] current_cluster;
        logic [SECTOR_W-1:0]  sector_in_cluster;
        logic [SLOT_W-1:0]    entry_slot;
        logic                 finished;
    } t_walk_state;

    typedef struct packed {
        logic [SHIFT_W-1:0]   cluster_shift;
        logic [CLUSTER_W-1:0] fat_start_cluster;
        logic [CLUSTER_W-1:0] root_cluster;
    } t_cfg;

    // Disk sector of a sector within a cluster.
    function automatic logic [ADDR_W-1:0] sector_of(
        input logic [CLUSTER_W-1:0] cluster,
        input logic [SHIFT_W-1:0]   shift,
        input logic [SECTOR_W-1:0]  sector
    );
        return (ADDR_W'(cluster) << shift) + ADDR_W'(sector);
    endfunction

endpackage

/* design/fdw_step.sv */
module fdw_step (
    input  fdw_pkg::t_walk_state              i_state,
    input  fdw_pkg::t_cfg                     i_cfg,
    input  logic [fdw_pkg::CMD_W-1:0]         i_command,
    input  logic [fdw_pkg::CLUSTER_W-1:0]     i_start_cluster,
    input  logic [fdw_pkg::BYTE_W-1:0]        i_first_byte,
    input  logic [fdw_pkg::CLUSTER_W-1:0]     i_fat_word,
    output fdw_pkg::t_walk_state              o_state,
    output fdw_pkg::t_result                  o_res0,
    output fdw_pkg::t_result                  o_res1,
    output logic [1:0]                        o_count
);

    logic [fdw_pkg::CLUSTER_W-1:0] open_cluster;
    logic [fdw_pkg::SECTOR_W-1:0]  last_sector;
    logic [fdw_pkg::SECTOR_W-1:0]  next_sector;
    logic [fdw_pkg::ADDR_W-1:0]    fat_sector;
    fdw_pkg::t_result              adv_res;
    logic                          adv_to_fat;

    // Cluster chosen by an open command; zero selects the root.
    assign open_cluster = (i_start_cluster != '0) ? i_start_cluster : i_cfg.root_cluster;

    // Read request once a sector is used up: next sector, or the FAT word.
    assign last_sector = fdw_pkg::SECTOR_W'((8'd1 << i_cfg.cluster_shift) - 8'd1);
    assign next_sector = i_state.sector_in_cluster + 1'b1;
    assign adv_to_fat  = (i_state.sector_in_cluster >= last_sector);
    assign fat_sector  = (fdw_pkg::ADDR_W'(i_cfg.fat_start_cluster) << i_cfg.cluster_shift)
                       + fdw_pkg::ADDR_W'(i_state.current_cluster[15:8]);

    always_comb begin
        adv_res = '0;
        if (adv_to_fat) begin
            adv_res.kind           = fdw_pkg::KIND_FAT;
            adv_res.sector_address = fat_sector;
            adv_res.fat_word_index = i_state.current_cluster[7:0];
        end else begin
            adv_res.kind           = fdw_pkg::KIND_DATA;
            adv_res.sector_address = fdw_pkg::sector_of(i_state.current_cluster,
                                                         i_cfg.cluster_shift, next_sector);
        end
    end

    // One step of the walk for the accepted command.
    always_comb begin
        o_state = i_state;
        o_res0  = '0;
        o_res1  = '0;
        o_count = 2'd0;
        case (i_command)
            fdw_pkg::CMD_OPEN: begin
                o_state.current_cluster   = open_cluster;
                o_state.sector_in_cluster = '0;
                o_state.entry_slot        = '0;
                o_state.finished          = 1'b0;
                o_res0.kind               = fdw_pkg::KIND_DATA;
                o_res0.sector_address     = fdw_pkg::sector_of(open_cluster,
                                                i_cfg.cluster_shift, '0);
                o_count                   = 2'd1;
            end
            fdw_pkg::CMD_ENTRY: begin
                if (i_state.finished) begin
                    o_res0.kind = fdw_pkg::KIND_END;
                    o_count     = 2'd1;
                end else if (i_state.entry_slot
                             < fdw_pkg::SLOT_W'(fdw_pkg::ENTRIES_PER_SECTOR)) begin
                    o_state.entry_slot = i_state.entry_slot + 1'b1;
                    if (i_first_byte == fdw_pkg::NAME_END) begin
                        o_state.finished = 1'b1;
                        o_res0.kind      = fdw_pkg::KIND_END;
                        o_count          = 2'd1;
                    end else begin
                        if (i_first_byte != fdw_pkg::NAME_FREE) begin
                            o_res0.kind        = fdw_pkg::KIND_ENTRY;
                            o_res0.entry_index = i_state.entry_slot[3:0];
                            o_count            = 2'd1;
                        end
                        // Last slot of the sector: ask for the next read at once.
                        if (i_state.entry_slot
                            == fdw_pkg::SLOT_W'(fdw_pkg::ENTRIES_PER_SECTOR - 1)) begin
                            if (adv_to_fat) begin
                                o_state.entry_slot =
                                    fdw_pkg::SLOT_W'(fdw_pkg::ENTRIES_PER_SECTOR);
                            end else begin
                                o_state.sector_in_cluster = next_sector;
                                o_state.entry_slot        = '0;
                            end
                            if (o_count == 2'd1) begin
                                o_res1 = adv_res;
                            end else begin
                                o_res0 = adv_res;
                            end
                            o_count = o_count + 2'd1;
                        end
                    end
                end
            end
            fdw_pkg::CMD_FAT: begin
                if (!i_state.finished && i_state.entry_slot
                    >= fdw_pkg::SLOT_W'(fdw_pkg::ENTRIES_PER_SECTOR)) begin
                    o_state.current_cluster = i_fat_word;
                    if (i_fat_word >= fdw_pkg::CHAIN_END) begin
                        o_state.finished = 1'b1;
                        o_res0.kind      = fdw_pkg::KIND_END;
                    end else begin
                        o_state.sector_in_cluster = '0;
                        o_state.entry_slot        = '0;
                        o_res0.kind               = fdw_pkg::KIND_DATA;
                        o_res0.sector_address     = fdw_pkg::sector_of(i_fat_word,
                                                        i_cfg.cluster_shift, '0);
                    end
                    o_count = 2'd1;
                end
            end
            default: begin
                o_count = 2'd0;
            end
        endcase
        // Mark the final result of this command.
        o_res0.last = (o_count == 2'd1);
        o_res1.last = (o_count == 2'd2);
    end

endmodule

/* design/fdw_result_fifo.sv */
module fdw_result_fifo #(
    parameter int DEPTH = fdw_pkg::FIFO_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push0,
    input  logic                         i_push1,
    input  fdw_pkg::t_result             i_data0,
    input  fdw_pkg::t_result             i_data1,
    input  logic                         i_pop,
    output fdw_pkg::t_result             o_head,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = $clog2(DEPTH);

    fdw_pkg::t_result   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   wr_ptr1;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               pop_ok;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Pointer and fill count bookkeeping.
    assign pop_ok   = i_pop && (r_count != '0);
    assign wr_ptr1  = ptr_inc(r_wr_ptr);
    assign n_wr_ptr = i_push1 ? ptr_inc(wr_ptr1) : (i_push0 ? wr_ptr1 : r_wr_ptr);
    assign n_rd_ptr = pop_ok ? ptr_inc(r_rd_ptr) : r_rd_ptr;
    assign n_count  = r_count + CNT_W'(i_push0) + CNT_W'(i_push1) - CNT_W'(pop_ok);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage; the second result of a command lands in the following slot.
    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push1) begin
            r_mem[wr_ptr1] <= i_data1;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

/* design/fat16_directory_walker.sv */
// FAT16 directory walker.
// Input channel (i_in_valid / o_in_ready): one command per transfer. Open
// starts a walk at a cluster (zero selects the root cluster), entry carries
// the first name byte of the next 32-byte entry, and FAT returns the word
// asked for by an earlier FAT read request.
// Output channel (o_out_valid / i_out_ready): zero, one or two results per
// command, in order, o_last set on the final one of each command.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): writes
// the cluster shift, FAT start and root cluster; the user must write them
// only while the block is idle, which the block itself does not enforce.
// With the queue empty, a command's first result is offered in the cycle
// after its transfer; a second result follows once the first is taken.
// Throughput: one command per cycle while commands leave at most one result
// each. The walk state is updated in the accepting cycle and results go into
// a small result queue; o_in_ready depends only on the queue fill, and is
// high while room for two results remains. When the receiver stalls, the
// queue fills and o_in_ready drops.
// Reset clears the configuration to zero, empties the queue and leaves no
// directory open, so entry commands report end of directory.
module fat16_directory_walker #(
    parameter int FIFO_DEPTH = fdw_pkg::FIFO_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [fdw_pkg::CMD_W-1:0]          i_command,
    input  logic [fdw_pkg::CLUSTER_W-1:0]      i_start_cluster,
    input  logic [fdw_pkg::BYTE_W-1:0]         i_first_byte,
    input  logic [fdw_pkg::CLUSTER_W-1:0]      i_fat_word,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [1:0]                         o_kind,
    output logic [fdw_pkg::ADDR_W-1:0]         o_sector_address,
    output logic [fdw_pkg::WORD_IDX_W-1:0]     o_fat_word_index,
    output logic [fdw_pkg::ENTRY_IDX_W-1:0]    o_entry_index,
    output logic                               o_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fdw_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [fdw_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    fdw_pkg::t_cfg        r_cfg;
    fdw_pkg::t_walk_state r_state;
    fdw_pkg::t_walk_state n_state;
    fdw_pkg::t_result     res0;
    fdw_pkg::t_result     res1;
    fdw_pkg::t_result     head;
    logic [1:0]           res_count;
    logic [CNT_W-1:0]     fill;
    logic                 in_xfer;
    logic                 cfg_xfer;

    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = (fill <= CNT_W'(FIFO_DEPTH - 2));
    assign in_xfer     = i_in_valid && o_in_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_xfer) begin
            unique case (i_cfg_index)
                fdw_pkg::CFG_CLUSTER_SHIFT:
                    r_cfg.cluster_shift <= i_cfg_data[fdw_pkg::SHIFT_W-1:0];
                fdw_pkg::CFG_FAT_START:
                    r_cfg.fat_start_cluster <= i_cfg_data;
                fdw_pkg::CFG_ROOT_CLUSTER:
                    r_cfg.root_cluster <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Walk step between the state register and the result queue.
    fdw_step u_step (
        .i_state         (r_state),
        .i_cfg           (r_cfg),
        .i_command       (i_command),
        .i_start_cluster (i_start_cluster),
        .i_first_byte    (i_first_byte),
        .i_fat_word      (i_fat_word),
        .o_state         (n_state),
        .o_res0          (res0),
        .o_res1          (res1),
        .o_count         (res_count)
    );

    // Walk state; no directory is open after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{current_cluster: '0, sector_in_cluster: '0,
                         entry_slot: '0, finished: 1'b1};
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    fdw_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (in_xfer && (res_count != 2'd0)),
        .i_push1 (in_xfer && (res_count == 2'd2)),
        .i_data0 (res0),
        .i_data1 (res1),
        .i_pop   (i_out_ready),
        .o_head  (head),
        .o_count (fill)
    );

    assign o_out_valid      = (fill != '0);
    assign o_kind           = head.kind;
    assign o_sector_address = head.sector_address;
    assign o_fat_word_index = head.fat_word_index;
    assign o_entry_index    = head.entry_index;
    assign o_last           = head.last;

`ifndef NO_ASSERTIONS
    // The queue never holds more results than it has slots.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // A command that produces results shows one on the next cycle.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (res_count != 2'd0)) |=> o_out_valid)
        else $error("result not offered after accepted command");

    // Two results only come from a valid entry followed by a read request.
    a_pair_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (res_count == 2'd2)) |->
            (res0.kind == fdw_pkg::KIND_ENTRY) && !res0.last && res1.last &&
            ((res1.kind == fdw_pkg::KIND_DATA) || (res1.kind == fdw_pkg::KIND_FAT)))
        else $error("malformed result pair");

    // The entry slot never passes the awaiting-FAT mark.
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.entry_slot <= fdw_pkg::SLOT_W'(fdw_pkg::ENTRIES_PER_SECTOR))
        else $error("entry slot out of range");
`endif

endmodule

/* test/fdw_walk_checker.sv */
`timescale 1ns / 100ps

// Watches the three channels of the directory walker. It keeps its own copy
// of the walk state and the registers, predicts the results of every command
// transfer, and compares each result transfer against the oldest prediction.
module fdw_walk_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [fdw_pkg::CMD_W-1:0]       i_command,
    input  logic [fdw_pkg::CLUSTER_W-1:0]   i_start_cluster,
    input  logic [fdw_pkg::BYTE_W-1:0]      i_first_byte,
    input  logic [fdw_pkg::CLUSTER_W-1:0]   i_fat_word,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [1:0]                      i_kind,
    input  logic [fdw_pkg::ADDR_W-1:0]      i_sector_address,
    input  logic [fdw_pkg::WORD_IDX_W-1:0]  i_fat_word_index,
    input  logic [fdw_pkg::ENTRY_IDX_W-1:0] i_entry_index,
    input  logic                            i_last,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [fdw_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [fdw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_checked
);
    import fdw_pkg::*;

    // Register copies.
    logic [SHIFT_W-1:0]   shift_reg;
    logic [CLUSTER_W-1:0] fat_start_reg;
    logic [CLUSTER_W-1:0] root_reg;

    // Walk position.
    logic [CLUSTER_W-1:0] walk_cluster;
    logic [SECTOR_W-1:0]  sector_idx;
    logic [SLOT_W-1:0]    next_slot;
    logic                 walk_done;

    // Results predicted but not yet seen on the output channel.
    t_result pending_results[$];

    function automatic t_result make_result(input t_kind kind,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [WORD_IDX_W-1:0] word_idx,
                                            input logic [ENTRY_IDX_W-1:0] entry_idx);
        t_result r;
        r.kind           = kind;
        r.sector_address = addr;
        r.fat_word_index = word_idx;
        r.entry_index    = entry_idx;
        r.last           = 1'b0;
        return r;
    endfunction

    // Disk sector of the current position in the current cluster.
    function automatic logic [ADDR_W-1:0] walk_data_sector();
        return (ADDR_W'(walk_cluster) << shift_reg) + ADDR_W'(sector_idx);
    endfunction

    // Advance the walk by one command and queue the results it causes.
    task automatic follow_command(input logic [CMD_W-1:0] cmd,
                                  input logic [CLUSTER_W-1:0] start,
                                  input logic [BYTE_W-1:0] name_byte,
                                  input logic [CLUSTER_W-1:0] fat_next);
        t_result produced[$];
        logic [ENTRY_IDX_W-1:0] slot_now;
        case (cmd)
            CMD_OPEN: begin
                walk_cluster = (start != '0) ? start : root_reg;
                sector_idx   = '0;
                next_slot    = '0;
                walk_done    = 1'b0;
                produced.push_back(make_result(KIND_DATA, walk_data_sector(), '0, '0));
            end
            CMD_ENTRY: begin
                if (walk_done) begin
                    produced.push_back(make_result(KIND_END, '0, '0, '0));
                end else if (next_slot < ENTRIES_PER_SECTOR) begin
                    slot_now  = next_slot[ENTRY_IDX_W-1:0];
                    next_slot = next_slot + 1'b1;
                    if (name_byte == NAME_END) begin
                        walk_done = 1'b1;
                        produced.push_back(make_result(KIND_END, '0, '0, '0));
                    end else begin
                        if (name_byte != NAME_FREE)
                            produced.push_back(make_result(KIND_ENTRY, '0, '0, slot_now));
                        // Sector used up: ask for the next one, or for the FAT
                        // word once the cluster (as now configured) is done.
                        if (next_slot >= ENTRIES_PER_SECTOR) begin
                            if (int'(sector_idx) >= (1 << shift_reg) - 1) begin
                                next_slot = SLOT_W'(ENTRIES_PER_SECTOR);
                                produced.push_back(make_result(KIND_FAT,
                                    (ADDR_W'(fat_start_reg) << shift_reg)
                                        + ADDR_W'(walk_cluster >> 8),
                                    walk_cluster[WORD_IDX_W-1:0], '0));
                            end else begin
                                sector_idx = sector_idx + 1'b1;
                                next_slot  = '0;
                                produced.push_back(make_result(KIND_DATA,
                                    walk_data_sector(), '0, '0));
                            end
                        end
                    end
                end
            end
            CMD_FAT: begin
                if (!walk_done && next_slot >= ENTRIES_PER_SECTOR) begin
                    walk_cluster = fat_next;
                    if (fat_next >= CHAIN_END) begin
                        walk_done = 1'b1;
                        produced.push_back(make_result(KIND_END, '0, '0, '0));
                    end else begin
                        sector_idx = '0;
                        next_slot  = '0;
                        produced.push_back(make_result(KIND_DATA, walk_data_sector(), '0, '0));
                    end
                end
            end
            default: begin
            end
        endcase
        if (produced.size() != 0) begin
            produced[produced.size() - 1].last = 1'b1;
            foreach (produced[i])
                pending_results.push_back(produced[i]);
        end
    endtask

    task automatic report_field(input string field,
                                input logic [ADDR_W-1:0] want,
                                input logic [ADDR_W-1:0] got);
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, field, want, got);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            shift_reg     = '0;
            fat_start_reg = '0;
            root_reg      = '0;
            walk_cluster  = '0;
            sector_idx    = '0;
            next_slot     = '0;
            walk_done     = 1'b1;
            o_errors      = 0;
            o_checked     = 0;
            pending_results.delete();
        end else begin
            // Result transfer first, so a result never meets its own command.
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual kind %0d",
                             $time, i_kind);
                    o_errors++;
                end else begin
                    want = pending_results.pop_front();
                    o_checked++;
                    if (i_kind !== want.kind)
                        report_field("kind", ADDR_W'(want.kind), ADDR_W'(i_kind));
                    if (i_sector_address !== want.sector_address)
                        report_field("sector_address", want.sector_address,
                                     i_sector_address);
                    if (i_fat_word_index !== want.fat_word_index)
                        report_field("fat_word_index", ADDR_W'(want.fat_word_index),
                                     ADDR_W'(i_fat_word_index));
                    if (i_entry_index !== want.entry_index)
                        report_field("entry_index", ADDR_W'(want.entry_index),
                                     ADDR_W'(i_entry_index));
                    if (i_last !== want.last)
                        report_field("last", ADDR_W'(want.last), ADDR_W'(i_last));
                end
            end

            // Register write transfer.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CLUSTER_SHIFT: shift_reg     = i_cfg_data[SHIFT_W-1:0];
                    CFG_FAT_START:     fat_start_reg = i_cfg_data;
                    CFG_ROOT_CLUSTER:  root_reg      = i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // Command transfer.
            if (i_in_valid && i_in_ready)
                follow_command(i_command, i_start_cluster, i_first_byte, i_fat_word);
        end
        o_pending = pending_results.size();
    end

endmodule

/* test/fat16_directory_walker_tb.sv */
`timescale 1ns / 100ps

// Drives directory walks into the walker and gives the verdict; the checker
// beside the block does all prediction and comparison.
module fat16_directory_walker_tb;
    import fdw_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam int               QUIET_LIMIT = 2000;
    localparam int               PHASES      = 8;
    localparam int               PHASE_ITEMS = 90;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [CMD_W-1:0]       i_command;
    logic [CLUSTER_W-1:0]   i_start_cluster;
    logic [BYTE_W-1:0]      i_first_byte;
    logic [CLUSTER_W-1:0]   i_fat_word;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [1:0]             o_kind;
    logic [ADDR_W-1:0]      o_sector_address;
    logic [WORD_IDX_W-1:0]  o_fat_word_index;
    logic [ENTRY_IDX_W-1:0] o_entry_index;
    logic                   o_last;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int errors;
    int pending;
    int checked;

    // Stimulus bookkeeping: a rough view of where the walk stands, used only
    // to shape well-formed sequences.
    int cur_shift;
    bit walk_open;
    bit walk_wait_fat;
    int walk_slot;
    int walk_sector;
    bit tx_steady;
    bit rx_steady;
    int sent;
    int useful;
    int settings;
    int quiet;

    fat16_directory_walker i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_start_cluster  (i_start_cluster),
        .i_first_byte     (i_first_byte),
        .i_fat_word       (i_fat_word),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_sector_address (o_sector_address),
        .o_fat_word_index (o_fat_word_index),
        .o_entry_index    (o_entry_index),
        .o_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    fdw_walk_checker walk_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_start_cluster  (i_start_cluster),
        .i_first_byte     (i_first_byte),
        .i_fat_word       (i_fat_word),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_kind           (o_kind),
        .i_sector_address (o_sector_address),
        .i_fat_word_index (o_fat_word_index),
        .i_entry_index    (o_entry_index),
        .i_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_errors         (errors),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: ends the run if no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet <= 0;
        end else begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t ns: no transfer for %0d cycles", $time, quiet);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Result receiver: a random stall before each transfer, with stretches
    // of no stalls at all.
    initial begin
        int stall;
        int taken;
        i_out_ready = 1'b0;
        rx_steady   = 1'b0;
        taken       = 0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            @(negedge i_clk);
            taken++;
            if (taken % 32 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
        end
    end

    // One command transfer, after a random gap. Entered and left at a
    // falling edge.
    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic [CLUSTER_W-1:0] start,
                                input logic [BYTE_W-1:0] name_byte,
                                input logic [CLUSTER_W-1:0] fat_next);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_start_cluster <= start;
        i_first_byte    <= name_byte;
        i_fat_word      <= fat_next;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        @(negedge i_clk);
        sent++;
        if (sent % 40 == 0)
            tx_steady = ($urandom_range(0, 3) == 0);
    endtask

    task automatic open_dir(input logic [CLUSTER_W-1:0] start);
        send_command(CMD_OPEN, start, BYTE_W'($urandom), CLUSTER_W'($urandom));
        walk_open     = 1'b1;
        walk_wait_fat = 1'b0;
        walk_slot     = 0;
        walk_sector   = 0;
    endtask

    task automatic give_entry(input logic [BYTE_W-1:0] name_byte);
        send_command(CMD_ENTRY, CLUSTER_W'($urandom), name_byte, CLUSTER_W'($urandom));
        if (walk_open && !walk_wait_fat) begin
            walk_slot++;
            if (name_byte == NAME_END) begin
                walk_open = 1'b0;
            end else if (walk_slot == ENTRIES_PER_SECTOR) begin
                if (walk_sector >= (1 << cur_shift) - 1) begin
                    walk_wait_fat = 1'b1;
                end else begin
                    walk_sector++;
                    walk_slot = 0;
                end
            end
        end
    endtask

    task automatic give_fat_word(input logic [CLUSTER_W-1:0] fat_next);
        send_command(CMD_FAT, CLUSTER_W'($urandom), BYTE_W'($urandom), fat_next);
        if (walk_open && walk_wait_fat) begin
            if (fat_next >= CHAIN_END) begin
                walk_open = 1'b0;
            end else begin
                walk_wait_fat = 1'b0;
                walk_slot     = 0;
                walk_sector   = 0;
            end
        end
    endtask

    // Drop valid, let every predicted result drain, and then let the clock run
    // on to cover commands that cause none.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_transfer(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
    endtask

    // Write all three registers back to back; the shift goes in with random
    // upper bits, which the block must drop.
    task automatic program_regs(input int shift, input logic [CLUSTER_W-1:0] fat_start,
                                input logic [CLUSTER_W-1:0] root);
        cfg_transfer(CFG_CLUSTER_SHIFT,
                     {(CFG_DATA_W - SHIFT_W)'($urandom), SHIFT_W'(shift)});
        cfg_transfer(CFG_FAT_START, fat_start);
        cfg_transfer(CFG_ROOT_CLUSTER, root);
        i_cfg_valid <= 1'b0;
        cur_shift = shift;
        settings++;
    endtask

    function automatic logic [CLUSTER_W-1:0] pick_start();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return '0;
        else if (r < 30)
            return '1;
        return CLUSTER_W'($urandom);
    endfunction

    // Name bytes lean toward live entries, with deleted ones and the
    // occasional end marker, more often in the last slot of a sector.
    function automatic logic [BYTE_W-1:0] pick_name_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < ((walk_slot == ENTRIES_PER_SECTOR - 1) ? 12 : 2))
            return NAME_END;
        else if (r < 25)
            return NAME_FREE;
        return BYTE_W'($urandom_range(1, 255));
    endfunction

    // One random command, mostly continuing the walk in progress.
    task automatic random_step();
        int r;
        r = $urandom_range(0, 99);
        if (!walk_open) begin
            if (r < 75) begin
                open_dir(pick_start());
                useful++;
            end else if (r < 88) begin
                give_entry(BYTE_W'($urandom));
                useful++;
            end else if (r < 94) begin
                give_fat_word(CLUSTER_W'($urandom));
            end else begin
                send_command(CMD_UNUSED, CLUSTER_W'($urandom), BYTE_W'($urandom),
                             CLUSTER_W'($urandom));
            end
        end else if (r < 3) begin
            open_dir(pick_start());
            useful++;
        end else if (r < 8) begin
            send_command(CMD_UNUSED, CLUSTER_W'($urandom), BYTE_W'($urandom),
                         CLUSTER_W'($urandom));
        end else if (r < 12) begin
            // Out-of-turn commands that the block must ignore.
            if (walk_wait_fat)
                give_entry(BYTE_W'($urandom));
            else
                give_fat_word(CLUSTER_W'($urandom));
        end else if (walk_wait_fat) begin
            if ($urandom_range(0, 99) < 15)
                give_fat_word(CLUSTER_W'($urandom_range(CHAIN_END, 16'hFFFF)));
            else
                give_fat_word(CLUSTER_W'($urandom_range(0, CHAIN_END - 1)));
            useful++;
        end else begin
            give_entry(pick_name_byte());
            useful++;
        end
    endtask

    initial begin
        int shift_plan[PHASES];
        logic [BYTE_W-1:0] sector_bytes[ENTRIES_PER_SECTOR];
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_command       = CMD_OPEN;
        i_start_cluster = '0;
        i_first_byte    = '0;
        i_fat_word      = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_CLUSTER_SHIFT;
        i_cfg_data      = '0;
        sent            = 0;
        useful          = 0;
        settings        = 0;
        cur_shift       = 0;
        walk_open       = 1'b0;
        walk_wait_fat   = 1'b0;
        walk_slot       = 0;
        walk_sector     = 0;
        tx_steady       = 1'b0;
        shift_plan      = '{1, 0, 3, 0, 2, 7, 1, 0};
        sector_bytes    = '{8'hFF, NAME_FREE, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h20, 8'h2E,
                            8'h41, 8'h5A, 8'h10, 8'h02, 8'h04, 8'h08, 8'h40, NAME_FREE};

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Nothing open yet: entry reports the end, the rest are ignored.
        give_entry(8'h41);
        give_fat_word(16'h1234);
        send_command(CMD_UNUSED, '1, '1, '1);
        settle();

        // One full sector at one sector per cluster, ending in a deleted
        // entry, so the FAT request is the only result of the last slot.
        program_regs(0, 16'hABCD, 16'hFFFF);
        open_dir('0);
        open_dir(16'hFFFF);
        foreach (sector_bytes[i])
            give_entry(sector_bytes[i]);
        give_entry(8'h55);
        give_fat_word(16'h0100);
        give_entry(NAME_END);
        give_entry(8'hAA);

        // Random walks under a series of register settings; walks carry over
        // from one setting to the next, so the shift also drops mid-walk.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            if (p == 0)
                program_regs(shift_plan[p], '0, '0);
            else if (p == 1)
                program_regs(shift_plan[p], '1, '1);
            else
                program_regs(shift_plan[p], CLUSTER_W'($urandom), CLUSTER_W'($urandom));
            tx_steady = ($urandom_range(0, 3) == 0);
            while (useful < (p + 1) * PHASE_ITEMS)
                random_step();
        end

        settle();
        repeat (8) @(negedge i_clk);

        $display("Sent %0d commands (%0d random walk steps) under %0d register settings.",
                 sent, useful, settings);
        $display("Checked %0d results, %0d mismatches.", checked, errors);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
